// ===== hw/rtl/exr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exr_pkg
// Shared constants, types and helpers for the Euler xyz rotation matrix block.
// ----------------------------------------------------------------------------
package exr_pkg;

   localparam int Q = 30;
   localparam logic [31:0] QUARTER = 32'h4000_0000;

   // Polynomial coefficients (pi/2)^k / k! in Q30, k = 1, 3, ..., 13
   localparam int NUM_COEF = 7;
   typedef logic [30:0] coef_type;
   localparam coef_type COEF [NUM_COEF] = '{
      31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
      31'd172272, 31'd3864, 31'd61
   };

   // Signed Q30 value in 32 bits, range -2.0 to just under +2.0
   typedef logic signed [31:0] q30_type;

   // Data handed from one polynomial cell to the next
   typedef struct packed {
      logic        neg;
      logic [30:0] u;
      logic [30:0] u2;
      logic [30:0] p;
   } sin_lane_type;

   // Q30 * Q30 rounded back to Q30
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic signed [63:0] prod;
      logic signed [63:0] rnd;
      begin
         prod = a * b;
         rnd  = prod + 64'sd536870912;
         return q30_type'(rnd >>> Q);
      end
   endfunction

endpackage

// ===== hw/rtl/euler_xyz_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_xyz_rotation_matrix
// Builds the x-y-z rotation matrix from three binary angles.
// ----------------------------------------------------------------------------
// Takes one word of three angles per cycle while the output is not stalled and
// returns one word of nine Q1.14 entries per word taken. The result passes
// through eleven register stages, the first loaded at the taking edge: front,
// the chain of six Horner cells of the sine polynomial, sine, two product
// stages and the rounding stage. The whole pipe advances together when the
// output register is free or being drained.
module euler_xyz_rotation_matrix
   import exr_pkg::*;
#(
   parameter int ANGLE_WIDTH = 16,
   parameter int FRAC_BITS   = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // angle_x, angle_y, angle_z from bit 0 up, zero padded to whole bytes
   input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, zero padded
   output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] rsp_tdata
);

   localparam int OW    = FRAC_BITS + 2;
   localparam int RW    = ((9*OW+7)/8)*8;
   localparam int SH    = Q - FRAC_BITS;
   localparam int DEPTH = 11;

   logic                 adv;
   logic [DEPTH-1:0]     vld_ff;
   logic [DEPTH-1:0]     vld_in;

   // Advance the pipe whenever the output slot can take a word
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Stage 0: phase, quadrant fold, u and u2 for six sines
   sin_lane_type [5:0] lane0_ff;
   sin_lane_type [5:0] lane0_in;
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         logic [ANGLE_WIDTH-1:0] a;
         logic [31:0] ph;
         logic [30:0] u;
         logic [61:0] sq;
         a  = req_tdata[(i/2)*ANGLE_WIDTH +: ANGLE_WIDTH];
         ph = 32'(a) << (32 - ANGLE_WIDTH);
         if (i % 2 == 1) ph = ph + QUARTER;
         u  = ph[30] ? (31'h4000_0000 - {1'b0, ph[29:0]}) : {1'b0, ph[29:0]};
         sq = u * u;
         lane0_in[i].neg = ph[31];
         lane0_in[i].u   = u;
         lane0_in[i].u2  = sq[60:30];
         lane0_in[i].p   = COEF[NUM_COEF-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) lane0_ff <= lane0_in;
   end

   // Horner chain of cells
   sin_lane_type [5:0] chain [7];
   assign chain[0] = lane0_ff;
   for (genvar g = 0; g < 6; g++) begin : g_cell
      exr_sin_cell #(.LANES(6), .K(5-g)) u_cell (
         .clock  (clock),
         .enable (adv),
         .lane_i (chain[g]),
         .lane_o (chain[g+1])
      );
   end

   // Final sine multiply, clamp and sign: sx cx sy cy sz cz
   q30_type sc_ff [6];
   q30_type sc_in [6];
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         logic [61:0] pr;
         logic [30:0] s;
         pr = chain[6][i].p * chain[6][i].u;
         s  = (pr[60:30] > 31'h4000_0000) ? 31'h4000_0000 : pr[60:30];
         sc_in[i] = chain[6][i].neg ? -q30_type'({1'b0, s}) : q30_type'({1'b0, s});
      end
   end
   always_ff @(posedge clock) begin
      if (adv) sc_ff <= sc_in;
   end

   // First products
   q30_type sxsy_ff, cxsy_ff, cycz_ff, cysz_ff, sxcy_ff, cxcy_ff;
   q30_type cxsz_ff, sxsz_ff, cxcz_ff, sxcz_ff, sz_ff, cz_ff, sy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sxsy_ff <= mul_q30(sc_ff[0], sc_ff[2]);
         cxsy_ff <= mul_q30(sc_ff[1], sc_ff[2]);
         cycz_ff <= mul_q30(sc_ff[3], sc_ff[5]);
         cysz_ff <= mul_q30(sc_ff[3], sc_ff[4]);
         sxcy_ff <= mul_q30(sc_ff[0], sc_ff[3]);
         cxcy_ff <= mul_q30(sc_ff[1], sc_ff[3]);
         cxsz_ff <= mul_q30(sc_ff[1], sc_ff[4]);
         sxsz_ff <= mul_q30(sc_ff[0], sc_ff[4]);
         cxcz_ff <= mul_q30(sc_ff[1], sc_ff[5]);
         sxcz_ff <= mul_q30(sc_ff[0], sc_ff[5]);
         sz_ff   <= sc_ff[4];
         cz_ff   <= sc_ff[5];
         sy_ff   <= sc_ff[2];
      end
   end

   // Second products and sums, Q30 with headroom
   typedef logic signed [33:0] sum_type;
   sum_type sum_ff [9];
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff[0] <= sum_type'(cycz_ff);
         sum_ff[1] <= sum_type'(mul_q30(sxsy_ff, cz_ff)) + sum_type'(cxsz_ff);
         sum_ff[2] <= sum_type'(sxsz_ff) - sum_type'(mul_q30(cxsy_ff, cz_ff));
         sum_ff[3] <= -sum_type'(cysz_ff);
         sum_ff[4] <= sum_type'(cxcz_ff) - sum_type'(mul_q30(sxsy_ff, sz_ff));
         sum_ff[5] <= sum_type'(mul_q30(cxsy_ff, sz_ff)) + sum_type'(sxcz_ff);
         sum_ff[6] <= sum_type'(sy_ff);
         sum_ff[7] <= -sum_type'(sxcy_ff);
         sum_ff[8] <= sum_type'(cxcy_ff);
      end
   end

   // Round to nearest, saturate, pack into the output register
   logic [RW-1:0] out_ff;
   logic [RW-1:0] out_in;
   always_comb begin
      out_in = '0;
      for (int i = 0; i < 9; i++) begin
         logic signed [34:0] r;
         logic signed [34:0] lim;
         r   = (35'(sum_ff[i]) + (35'sd1 <<< (SH-1))) >>> SH;
         lim = 35'sd1 <<< FRAC_BITS;
         if (r > lim) r = lim;
         if (r < -lim) r = -lim;
         out_in[i*OW +: OW] = r[OW-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end
   assign rsp_tdata = out_ff;

   // Valid shift line
   assign vld_in = {vld_ff[DEPTH-2:0], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end
   assign rsp_tvalid = vld_ff[DEPTH-1];

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(vld_ff))
      else $error("pipe moved during stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready not tied to output slot");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted word lost");
`endif

endmodule

// ===== hw/rtl/exr_sin_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exr_sin_cell
// One Horner step of the sine polynomial: p <- c - (p*u2 >> 30), registered.
// ----------------------------------------------------------------------------
module exr_sin_cell
   import exr_pkg::*;
#(
   parameter int LANES = 6,
   parameter int K     = 5
) (
   input  logic                      clock,
   input  logic                      enable,
   input  sin_lane_type [LANES-1:0]  lane_i,
   output sin_lane_type [LANES-1:0]  lane_o
);

   sin_lane_type [LANES-1:0] lane_ff;
   sin_lane_type [LANES-1:0] lane_in;

   // Advance each lane one polynomial step
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         logic [61:0] prod;
         prod       = lane_i[i].p * lane_i[i].u2;
         lane_in[i] = lane_i[i];
         lane_in[i].p = COEF[K] - prod[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_o = lane_ff;

endmodule
